[rtl/assert_macros.svh]
// Assertion helpers used by the top-level decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tpld_pkg.sv]
package tpld_pkg;

  localparam int ChannelCount = 3;
  localparam int ChW = 2;

  typedef enum logic [3:0] {
    PH_OPCODE  = 4'd0,
    PH_SAMPLE  = 4'd1,
    PH_ENVB_HI = 4'd2,
    PH_ENVB_LO = 4'd3,
    PH_ENV1_HI = 4'd4,
    PH_ENV1_LO = 4'd5,
    PH_SKIP    = 4'd6,
    PH_DELAY   = 4'd7,
    PH_IGN1    = 4'd8,
    PH_IGN2    = 4'd9,
    PH_WLO     = 4'd10,
    PH_WHI     = 4'd11,
    PH_PARAM   = 4'd12,
    PH_VHI     = 4'd13,
    PH_VLO     = 4'd14
  } phase_t;

  localparam logic [7:0] NoteNone = 8'hFF;
  localparam logic [7:0] NoteOff  = 8'hFE;

  // Raw effect opcodes and remapped effect numbers
  localparam logic [3:0] RawGlissUp  = 4'd1;
  localparam logic [3:0] RawPorta    = 4'd2;
  localparam logic [3:0] RawSmpOfs   = 4'd3;
  localparam logic [3:0] RawOrnOfs   = 4'd4;
  localparam logic [3:0] RawVibrato  = 4'd5;
  localparam logic [3:0] RawEnvSlide = 4'd8;
  localparam logic [3:0] RawSpeed    = 4'd9;

  localparam logic [3:0] EffGliss    = 4'd1;
  localparam logic [3:0] EffPorta    = 4'd3;
  localparam logic [3:0] EffSmpOfs   = 4'd4;
  localparam logic [3:0] EffOrnOfs   = 4'd5;
  localparam logic [3:0] EffVibrato  = 4'd6;
  localparam logic [3:0] EffEnvSlide = 4'd9;
  localparam logic [3:0] EffSpeed    = 4'd11;

  typedef struct packed {
    logic             action;
    logic [ChW-1:0]   channel;
    logic [7:0]       data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [ChW-1:0] line_channel;
    logic [7:0]     note;
    logic [4:0]     sample_num;
    logic [3:0]     ornament_num;
    logic [3:0]     volume_level;
    logic [3:0]     envelope_shape;
    logic [15:0]    envelope_period;
    logic [3:0]     effect_number;
    logic [7:0]     effect_delay;
    logic [7:0]     effect_param;
    logic [4:0]     noise_offset;
    logic           pattern_end;
  } line_t;

  localparam int QDepth = 2;
  localparam int QPtrW = 1;
  localparam int QCntW = 2;

endpackage

[rtl/tpld_if.sv]
interface tpld_in_if;
  import tpld_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

interface tpld_out_if;
  import tpld_pkg::*;
  logic  valid;
  logic  ready;
  line_t beat;
  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

[rtl/tpld_front.sv]
// Front: registers input beats into a two-entry queue for the decoder.
module tpld_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  tpld_pkg::in_beat_t      in_beat,
  output logic                    q_valid,
  input  logic                    q_ready,
  output tpld_pkg::in_beat_t      q_beat
);
  import tpld_pkg::*;

  in_beat_t          mem_r [QDepth];
  logic [QPtrW-1:0]  wp_r, rp_r;
  logic [QCntW-1:0]  cnt_r;
  logic              push, pop;

  assign in_ready = (cnt_r != QCntW'(QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_ready;
  assign q_beat   = mem_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_beat;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + QCntW'(push) - QCntW'(pop);
    end
  end
endmodule

[rtl/tpld_back.sv]
// Back: per-byte parse state machine with a registered result stage.
module tpld_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  tpld_pkg::in_beat_t  q_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output tpld_pkg::line_t     out_beat
);
  import tpld_pkg::*;

  phase_t          phase_r, phase_nxt;
  logic            open_r, open_nxt;
  logic [ChW-1:0]  ch_r, ch_nxt;
  logic [7:0]      note_r, note_nxt;
  logic [4:0]      smp_r, smp_nxt;
  logic [3:0]      orn_r, orn_nxt;
  logic [3:0]      vol_r, vol_nxt;
  logic [3:0]      env_r, env_nxt;
  logic [15:0]     per_r, per_nxt;
  logic [3:0]      raw_r, raw_nxt;
  logic [3:0]      enum_r, enum_nxt;
  logic [7:0]      dly_r, dly_nxt;
  logic [7:0]      lo_r, lo_nxt;
  logic [7:0]      par_r, par_nxt;
  logic [4:0]      noise_r, noise_nxt;
  logic [3:0]      porn_r [ChannelCount];
  logic [3:0]      porn_wdata;
  logic            porn_we;
  logic [7:0]      skip_r [ChannelCount];
  logic            skip_we;
  logic            ov_r;
  line_t           ob_r;
  logic            emit, clr, go, pend;
  line_t           res;
  logic [7:0]      b;
  logic [ChW-1:0]  cch;
  logic [15:0]     w;
  logic [15:0]     negw;

  assign q_ready   = !ov_r || out_ready;
  assign go        = q_valid && q_ready;
  assign b         = q_beat.data_byte;
  assign out_valid = ov_r;
  assign out_beat  = ob_r;
  assign w         = {b, lo_r};
  assign negw      = 16'h0000 - w;

  // byte decode
  always_comb begin
    phase_nxt = phase_r; open_nxt = open_r; ch_nxt = ch_r; note_nxt = note_r;
    smp_nxt = smp_r; orn_nxt = orn_r; vol_nxt = vol_r; env_nxt = env_r;
    per_nxt = per_r; raw_nxt = raw_r; enum_nxt = enum_r; dly_nxt = dly_r;
    lo_nxt = lo_r; par_nxt = par_r; noise_nxt = noise_r;
    porn_we = 1'b0; porn_wdata = '0; skip_we = 1'b0;
    emit = 1'b0; clr = 1'b0; pend = 1'b0;
    cch = open_r ? ch_r : q_beat.channel;
    unique case (phase_r)
      PH_OPCODE: begin
        if (!open_r && (32'(q_beat.channel) >= ChannelCount)) begin
          // out-of-range channel: dropped
        end else if (!open_r && q_beat.channel == '0 && b == 8'h00) begin
          pend = 1'b1;
        end else begin
          open_nxt = 1'b1;
          ch_nxt   = cch;
          priority if (b >= 8'hf0) begin
            env_nxt = 4'd15; porn_we = 1'b1; porn_wdata = b[3:0];
            orn_nxt = b[3:0]; phase_nxt = PH_SAMPLE;
          end else if (b >= 8'hd1) begin
            smp_nxt = 5'(b - 8'hd0);
          end else if (b == 8'hd0) begin
            clr = 1'b1;
          end else if (b >= 8'hc1) begin
            vol_nxt = 4'(b - 8'hc0);
          end else if (b == 8'hc0) begin
            note_nxt = NoteOff; clr = 1'b1;
          end else if (b >= 8'hb2) begin
            env_nxt = 4'(b - 8'hb1); orn_nxt = porn_r[cch]; phase_nxt = PH_ENVB_HI;
          end else if (b == 8'hb1) begin
            phase_nxt = PH_SKIP;
          end else if (b == 8'hb0) begin
            env_nxt = 4'd15; orn_nxt = porn_r[cch];
          end else if (b >= 8'h50) begin
            note_nxt = b - 8'h50; clr = 1'b1;
          end else if (b >= 8'h40) begin
            if (b == 8'h40 && env_r == 4'd0) env_nxt = 4'd15;
            porn_we = 1'b1; porn_wdata = b[3:0]; orn_nxt = b[3:0];
          end else if (b >= 8'h20) begin
            noise_nxt = 5'(b - 8'h20);
          end else if (b >= 8'h10) begin
            orn_nxt = porn_r[cch];
            if (b == 8'h10) begin
              env_nxt = 4'd15; phase_nxt = PH_SAMPLE;
            end else begin
              env_nxt = b[3:0]; phase_nxt = PH_ENV1_HI;
            end
          end else if ((b >= 8'h01 && b <= 8'h05) || b == 8'h08 || b == 8'h09) begin
            raw_nxt = b[3:0];
          end else begin
            // unknown opcode: no effect
          end
          // line close: map raw effect
          if (clr) begin
            unique case (raw_nxt)
              RawGlissUp:  begin enum_nxt = EffGliss;    phase_nxt = PH_DELAY; end
              RawPorta:    begin enum_nxt = EffPorta;    phase_nxt = PH_DELAY; end
              RawSmpOfs:   begin enum_nxt = EffSmpOfs;   phase_nxt = PH_PARAM; end
              RawOrnOfs:   begin enum_nxt = EffOrnOfs;   phase_nxt = PH_PARAM; end
              RawVibrato:  begin enum_nxt = EffVibrato;  phase_nxt = PH_VHI;   end
              RawEnvSlide: begin enum_nxt = EffEnvSlide; phase_nxt = PH_DELAY; end
              RawSpeed:    begin enum_nxt = EffSpeed;    phase_nxt = PH_PARAM; end
              default:     begin enum_nxt = 4'd0;        emit = 1'b1;          end
            endcase
          end
        end
      end
      PH_SAMPLE:  begin smp_nxt = 5'(b >> 1); phase_nxt = PH_OPCODE; end
      PH_ENVB_HI: begin per_nxt = {b, 8'h00}; phase_nxt = PH_ENVB_LO; end
      PH_ENV1_HI: begin per_nxt = {b, 8'h00}; phase_nxt = PH_ENV1_LO; end
      PH_ENVB_LO: begin per_nxt = per_r | {8'h00, b}; phase_nxt = PH_OPCODE; end
      PH_ENV1_LO: begin per_nxt = per_r | {8'h00, b}; phase_nxt = PH_SAMPLE; end
      PH_SKIP:    begin skip_we = 1'b1; phase_nxt = PH_OPCODE; end
      PH_DELAY: begin
        dly_nxt = b;
        phase_nxt = (raw_r == RawPorta) ? PH_IGN1 : PH_WLO;
      end
      PH_IGN1:    phase_nxt = PH_IGN2;
      PH_IGN2:    phase_nxt = PH_WLO;
      PH_WLO:     begin lo_nxt = b; phase_nxt = PH_WHI; end
      PH_WHI: begin
        if (w[15]) begin
          par_nxt = negw[7:0];
          if (raw_r != RawPorta) enum_nxt = enum_r + 4'd1;
        end else begin
          par_nxt = w[7:0];
        end
        emit = 1'b1;
      end
      PH_PARAM:   begin par_nxt = b; emit = 1'b1; end
      PH_VHI:     begin par_nxt = {b[3:0], 4'h0}; phase_nxt = PH_VLO; end
      PH_VLO:     begin par_nxt = par_r + b; emit = 1'b1; end
      default:    phase_nxt = PH_OPCODE;
    endcase

    // result image
    res.line_channel    = ch_nxt;
    res.note            = note_nxt;
    res.sample_num      = smp_nxt;
    res.ornament_num    = orn_nxt;
    res.volume_level    = vol_nxt;
    res.envelope_shape  = env_nxt;
    res.envelope_period = per_nxt;
    res.effect_number   = enum_nxt;
    res.effect_delay    = dly_nxt;
    res.effect_param    = par_nxt;
    res.noise_offset    = noise_nxt;
    res.pattern_end     = 1'b0;
    if (pend) begin
      res = '0;
      res.note = NoteNone;
      res.noise_offset = noise_r;
      res.pattern_end = 1'b1;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n || (go && q_beat.action)) begin
      phase_r <= PH_OPCODE; open_r <= 1'b0; ch_r <= '0; note_r <= NoteNone;
      smp_r <= '0; orn_r <= '0; vol_r <= '0; env_r <= '0; per_r <= '0;
      raw_r <= '0; enum_r <= '0; dly_r <= '0; lo_r <= '0; par_r <= '0;
      noise_r <= '0;
      for (int i = 0; i < ChannelCount; i++) begin
        porn_r[i] <= '0;
        skip_r[i] <= 8'd1;
      end
    end else if (go) begin
      noise_r <= noise_nxt;
      if (porn_we) porn_r[cch] <= porn_wdata;
      if (skip_we) skip_r[ch_r] <= b;
      if (emit) begin
        phase_r <= PH_OPCODE; open_r <= 1'b0; ch_r <= '0; note_r <= NoteNone;
        smp_r <= '0; orn_r <= '0; vol_r <= '0; env_r <= '0; per_r <= '0;
        raw_r <= '0; enum_r <= '0; dly_r <= '0; lo_r <= '0; par_r <= '0;
      end else begin
        phase_r <= phase_nxt; open_r <= open_nxt; ch_r <= ch_nxt;
        note_r <= note_nxt; smp_r <= smp_nxt; orn_r <= orn_nxt;
        vol_r <= vol_nxt; env_r <= env_nxt; per_r <= per_nxt;
        raw_r <= raw_nxt; enum_r <= enum_nxt; dly_r <= dly_nxt;
        lo_r <= lo_nxt; par_r <= par_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (go && !q_beat.action && (emit || pend)) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (emit || pend)) ob_r <= res;
  end
endmodule

[rtl/tracker_pattern_line_decoder_top.sv]
// Tracker pattern line decoder: takes one pattern byte per beat and returns
// one decoded line per closed line (or a pattern-end beat). Throughput is one
// byte per cycle unless a result waits to be taken; an accepted byte passes through
// the two-entry input queue and the registered result stage. While a
// result waits to be taken the decoder holds; the queue absorbs up to two more
// bytes, after which the input stalls until the result is taken.
`include "assert_macros.svh"
module tracker_pattern_line_decoder_top (
  input  logic           clk,
  input  logic           rst_n,
  tpld_in_if.sink        in_ch,
  tpld_out_if.source     out_ch
);
  import tpld_pkg::*;

  logic     q_valid, q_ready;
  in_beat_t q_beat;

  tpld_front u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_beat (in_ch.beat),
    .q_valid, .q_ready, .q_beat
  );

  tpld_back u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_beat,
    .out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_beat (out_ch.beat)
  );

  `ASSERT_IMPL(a_pend_fields, clk, rst_n,
    out_ch.valid && out_ch.beat.pattern_end,
    out_ch.beat.line_channel == '0 && out_ch.beat.note == NoteNone,
    "pattern-end beat with line fields set")
  `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.beat), "result changed while stalled")
  `ASSERT_IMPL(a_q_ready, clk, rst_n, !out_ch.valid, q_ready,
    "decoder stalled with empty result stage")
endmodule
